>>> sv/tsrc_pkg.sv
// ----------------------------------------------------------------------------
// tsrc_pkg
// Shared types and constants for the time-server reply check and rank unit.
// ----------------------------------------------------------------------------
package tsrc_pkg;

	// Reply checking codes
	localparam logic [1:0] LEAP_UNSYNC = 2'd3;
	localparam logic [2:0] MODE_SERVER = 3'd4;
	localparam logic [7:0] STRATUM_KOD = 8'd0;

	// Result status codes
	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_UNSYNC     = 3'd1,
		ST_NOT_SERVER = 3'd2,
		ST_KISS       = 3'd3,
		ST_MISMATCH   = 3'd4
	} status_t;

	// Configuration register indexes
	typedef enum logic [0:0] {
		REG_SENT_SECONDS  = 1'b0,
		REG_SENT_FRACTION = 1'b1
	} reg_index_t;

	localparam int ADDR_W      = 3;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// One decoded reply
	typedef struct packed {
		logic        [1:0]  leap_flag;
		logic        [2:0]  reply_mode;
		logic        [7:0]  reply_stratum;
		logic        [31:0] echo_seconds;
		logic        [31:0] echo_fraction;
		logic signed [31:0] path_delay;
		logic        [31:0] server_address;
	} req_t;

	// One result
	typedef struct packed {
		logic        [2:0]  status;
		logic        [31:0] best_address;
		logic        [7:0]  best_stratum;
		logic signed [31:0] best_delay;
		logic        [15:0] best_sequence;
		logic        [3:0]  entries_held;
	} rsp_t;

	// Classified reply as it travels from front to back
	typedef struct packed {
		status_t            status;
		logic        [7:0]  stratum;
		logic signed [31:0] delay;
		logic        [31:0] address;
	} job_t;

	// Back end sequencer states
	typedef enum logic [1:0] {
		RK_IDLE,
		RK_INSERT,
		RK_REPORT
	} rank_state_t;

	// True when entry a ranks strictly after entry b
	function automatic logic ranks_after(
		input logic        [7:0]  strat_a,
		input logic signed [31:0] delay_a,
		input logic        [7:0]  strat_b,
		input logic signed [31:0] delay_b
	);
		logic res;
		if (strat_a != strat_b) begin
			res = strat_a > strat_b;
		end else begin
			res = delay_a > delay_b;
		end
		return res;
	endfunction

endpackage

>>> sv/time_server_reply_check_and_rank_unit.sv
// ----------------------------------------------------------------------------
// time_server_reply_check_and_rank_unit
// Checks decoded time-server replies and keeps a sorted table of the best.
// ----------------------------------------------------------------------------
//  channel   handshake                    payload
//  request   start / busy                 req  (tsrc_pkg::req_t)
//  result    done (one-cycle strobe)      rsp  (tsrc_pkg::rsp_t)
//  config    psel/penable/pwrite/pready   paddr, pwdata, prdata
//
//  A request is taken when start is high and busy is low; busy rises only
//  when the two-entry queue between front and back is full.
//  The back end steps through pop, insert and report for an accepted reply and
//  through pop and report for a rejected one; its sequencer sets that.
//  done is registered from the report state, which follows the pop and, for an
//  accepted reply, the insert, after any wait in the queue; results keep order.
//  Reset clears the entry count and arrival number; no clearing pass.
//  The result side cannot stall: done is asserted for exactly one cycle.
// ----------------------------------------------------------------------------
module time_server_reply_check_and_rank_unit #(
	parameter int TABLE_DEPTH = 11
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  tsrc_pkg::req_t                req,
	output logic                          done,
	output tsrc_pkg::rsp_t                rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tsrc_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	logic [31:0]          sent_seconds_q;
	logic [31:0]          sent_fraction_q;
	tsrc_pkg::reg_index_t reg_sel;
	logic                 cfg_write;
	logic                 queue_full;
	logic                 queue_empty;
	logic                 push;
	logic                 pop;
	tsrc_pkg::job_t       push_job;
	tsrc_pkg::job_t       pop_job;

	// Configuration port
	assign pready    = 1'b1;
	assign reg_sel   = tsrc_pkg::reg_index_t'(paddr[2]);
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_seconds_q  <= '0;
			sent_fraction_q <= '0;
		end else if (cfg_write) begin
			unique case (reg_sel)
				tsrc_pkg::REG_SENT_SECONDS:  sent_seconds_q  <= pwdata;
				tsrc_pkg::REG_SENT_FRACTION: sent_fraction_q <= pwdata;
				default: begin
					sent_seconds_q <= sent_seconds_q;
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			tsrc_pkg::REG_SENT_SECONDS:  prdata = sent_seconds_q;
			tsrc_pkg::REG_SENT_FRACTION: prdata = sent_fraction_q;
			default:                     prdata = '0;
		endcase
	end

	// Front: accept and classify
	tsrc_front u_front (
		.start         (start),
		.req           (req),
		.sent_seconds  (sent_seconds_q),
		.sent_fraction (sent_fraction_q),
		.queue_full    (queue_full),
		.busy          (busy),
		.push          (push),
		.job           (push_job)
	);

	// Queue between the two halves
	tsrc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_job),
		.pop       (pop),
		.pop_data  (pop_job),
		.full      (queue_full),
		.empty     (queue_empty)
	);

	// Back: rank table and result
	tsrc_rank #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_rank (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (queue_empty),
		.queue_data  (pop_job),
		.pop         (pop),
		.done        (done),
		.rsp         (rsp)
	);

endmodule

>>> sv/tsrc_front.sv
// ----------------------------------------------------------------------------
// tsrc_front
// Accepts replies and classifies them against the sent timestamp.
// ----------------------------------------------------------------------------
module tsrc_front (
	input  logic                  start,
	input  tsrc_pkg::req_t        req,
	input  logic [31:0]           sent_seconds,
	input  logic [31:0]           sent_fraction,
	input  logic                  queue_full,
	output logic                  busy,
	output logic                  push,
	output tsrc_pkg::job_t        job
);

	// Checks in priority order
	tsrc_pkg::status_t status;

	always_comb begin
		if (req.leap_flag == tsrc_pkg::LEAP_UNSYNC) begin
			status = tsrc_pkg::ST_UNSYNC;
		end else if (req.reply_mode != tsrc_pkg::MODE_SERVER) begin
			status = tsrc_pkg::ST_NOT_SERVER;
		end else if (req.reply_stratum == tsrc_pkg::STRATUM_KOD) begin
			status = tsrc_pkg::ST_KISS;
		end else if (req.echo_seconds != sent_seconds ||
				req.echo_fraction != sent_fraction) begin
			status = tsrc_pkg::ST_MISMATCH;
		end else begin
			status = tsrc_pkg::ST_OK;
		end
	end

	// Request goes straight into the queue
	assign busy        = queue_full;
	assign push        = start && !queue_full;
	assign job.status  = status;
	assign job.stratum = req.reply_stratum;
	assign job.delay   = req.path_delay;
	assign job.address = req.server_address;

endmodule

>>> sv/tsrc_queue.sv
// ----------------------------------------------------------------------------
// tsrc_queue
// Short FIFO of classified replies between front and back.
// ----------------------------------------------------------------------------
module tsrc_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  tsrc_pkg::job_t        push_data,
	input  logic                  pop,
	output tsrc_pkg::job_t        pop_data,
	output logic                  full,
	output logic                  empty
);

	tsrc_pkg::job_t                  slot_q [tsrc_pkg::QUEUE_DEPTH];
	logic [tsrc_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [tsrc_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [tsrc_pkg::QCNT_W-1:0]     cnt_q;

	assign full     = cnt_q == tsrc_pkg::QCNT_W'(tsrc_pkg::QUEUE_DEPTH);
	assign empty    = cnt_q == '0;
	assign pop_data = slot_q[rd_ptr_q];

	// Payload storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> sv/tsrc_rank.sv
// ----------------------------------------------------------------------------
// tsrc_rank
// Sorted ranking table of cells; inserts accepted replies and reports.
// ----------------------------------------------------------------------------
module tsrc_rank #(
	parameter int TABLE_DEPTH = 11
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  queue_empty,
	input  tsrc_pkg::job_t        queue_data,
	output logic                  pop,
	output logic                  done,
	output tsrc_pkg::rsp_t        rsp
);

	localparam int COUNT_W = $clog2(TABLE_DEPTH + 1);

	// Table cells
	logic        [31:0] addr_q  [TABLE_DEPTH];
	logic        [7:0]  strat_q [TABLE_DEPTH];
	logic signed [31:0] delay_q [TABLE_DEPTH];
	logic        [15:0] seq_q   [TABLE_DEPTH];

	logic [COUNT_W-1:0]       count_q;
	logic [15:0]              arrival_q;
	tsrc_pkg::job_t           job_q;
	tsrc_pkg::rank_state_t    state_q;
	tsrc_pkg::rank_state_t    state_d;
	tsrc_pkg::rsp_t           rsp_q;
	logic                     done_q;

	logic                     do_insert;
	logic                     do_report;
	logic [TABLE_DEPTH-1:0]   after_new;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tsrc_pkg::RK_IDLE: begin
				if (!queue_empty) begin
					state_d = (queue_data.status == tsrc_pkg::ST_OK) ?
						tsrc_pkg::RK_INSERT : tsrc_pkg::RK_REPORT;
				end
			end
			tsrc_pkg::RK_INSERT: state_d = tsrc_pkg::RK_REPORT;
			tsrc_pkg::RK_REPORT: state_d = tsrc_pkg::RK_IDLE;
			default:             state_d = tsrc_pkg::RK_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		pop       = 1'b0;
		do_insert = 1'b0;
		do_report = 1'b0;
		unique case (state_q)
			tsrc_pkg::RK_IDLE:   pop       = !queue_empty;
			tsrc_pkg::RK_INSERT: do_insert = 1'b1;
			tsrc_pkg::RK_REPORT: do_report = 1'b1;
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsrc_pkg::RK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold the popped request
	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= queue_data;
		end
	end

	// Per-cell compare: empty cells always rank after a new entry
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cmp
		assign after_new[i] = (COUNT_W'(i) >= count_q) ||
			tsrc_pkg::ranks_after(strat_q[i], delay_q[i], job_q.stratum, job_q.delay);
	end

	// Cells: keep, take the new entry, or take the neighbor above
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		localparam int UP = (i > 0) ? i - 1 : 0;
		logic load_new;
		logic load_up;
		if (i == 0) begin : g_head
			assign load_new = after_new[i];
			assign load_up  = 1'b0;
		end else begin : g_body
			assign load_new = after_new[i] && !after_new[i-1];
			assign load_up  = after_new[i-1];
		end

		always_ff @(posedge clk) begin
			if (do_insert) begin
				if (load_new) begin
					addr_q[i]  <= job_q.address;
					strat_q[i] <= job_q.stratum;
					delay_q[i] <= job_q.delay;
					seq_q[i]   <= arrival_q;
				end else if (load_up) begin
					addr_q[i]  <= addr_q[UP];
					strat_q[i] <= strat_q[UP];
					delay_q[i] <= delay_q[UP];
					seq_q[i]   <= seq_q[UP];
				end
			end
		end
	end

	// Entry count and arrival numbering
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			arrival_q <= '0;
		end else if (do_insert) begin
			arrival_q <= arrival_q + 16'd1;
			if (count_q != COUNT_W'(TABLE_DEPTH)) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (do_report) begin
			rsp_q.status       <= job_q.status;
			rsp_q.entries_held <= 4'(count_q);
			if (count_q == '0) begin
				rsp_q.best_address  <= '0;
				rsp_q.best_stratum  <= '0;
				rsp_q.best_delay    <= '0;
				rsp_q.best_sequence <= '0;
			end else begin
				rsp_q.best_address  <= addr_q[0];
				rsp_q.best_stratum  <= strat_q[0];
				rsp_q.best_delay    <= delay_q[0];
				rsp_q.best_sequence <= seq_q[0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= do_report;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(TABLE_DEPTH))
		else $error("rank table count beyond depth");

	a_insert_ok: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tsrc_pkg::RK_INSERT |-> job_q.status == tsrc_pkg::ST_OK)
		else $error("insert of a rejected reply");

	a_count_grows: assert property (@(posedge clk) disable iff (!arst_n)
		do_insert && count_q != COUNT_W'(TABLE_DEPTH) |=> count_q == $past(count_q) + 1'b1)
		else $error("count did not advance on insert");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe longer than one cycle");

	a_report_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q == tsrc_pkg::RK_INSERT || state_q == tsrc_pkg::RK_REPORT)
		else $error("popped request not processed");

endmodule
